FILE: src/bcc_pkg.sv
// Shared types and constants of the bilayer crossing counter.
`default_nettype none

package bcc_pkg;

    localparam int POS_W   = 10;
    localparam int SOUTH_W = 11;
    localparam int NODE_W  = 17;
    localparam int TOTAL_W = 32;
    localparam int CALC_W  = 12;

    localparam logic [SOUTH_W-1:0] SOUTH_RESET = 11'd1024;
    localparam logic [NODE_W-1:0]  NODE_MAX    = {NODE_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] south_position;
        logic             last_edge;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] crossing_total;
        logic               position_error;
        logic               total_saturated;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0]  node_next;
        logic [TOTAL_W-1:0] total_next;
        logic               sat;
    } t_step_res;

endpackage

`default_nettype wire

FILE: src/bcc_tree_mem.sv
// Node count memory of the accumulator tree: one write port, two registered read ports.
`default_nettype none

module bcc_tree_mem
    import bcc_pkg::*;
#(
    parameter int DEPTH = 2047,
    parameter int AW    = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [NODE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr_a,
    input  wire logic [AW-1:0]     i_raddr_b,
    output logic      [NODE_W-1:0] o_rdata_a,
    output logic      [NODE_W-1:0] o_rdata_b
);

    logic [NODE_W-1:0] r_mem [DEPTH];
    logic [NODE_W-1:0] r_rdata_a;
    logic [NODE_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

FILE: src/bcc_step_unit.sv
// Per-level arithmetic: saturating node increment and saturating total add.
`default_nettype none

module bcc_step_unit
    import bcc_pkg::*;
(
    input  wire logic [NODE_W-1:0]  i_node,
    input  wire logic [NODE_W-1:0]  i_sib,
    input  wire logic [TOTAL_W-1:0] i_total,
    input  wire logic               i_take_sib,
    output t_step_res               o_res
);

    logic [TOTAL_W:0] sum;

    always_comb begin
        sum = {1'b0, i_total} + (TOTAL_W+1)'(i_sib);
        o_res.node_next  = (i_node == NODE_MAX) ? i_node : i_node + NODE_W'(1);
        o_res.total_next = i_total;
        o_res.sat        = 1'b0;
        if (i_take_sib) begin
            if (sum[TOTAL_W]) begin
                o_res.total_next = TOTAL_MAX;
                o_res.sat        = 1'b1;
            end else begin
                o_res.total_next = sum[TOTAL_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/bilayer_crossing_counter.sv
// Top level of the bilayer crossing counter: sequencer, tree memory and step unit.
// Busy is high while an in-range edge walks the tree from leaf to root, writing back each
// level, so no new item is taken until the walk ends; an out-of-range edge that is not the
// last is taken without raising busy. On a last edge the result state registers the result
// strobe and starts a clearing pass over all 2*leaves_max-1 nodes (2047 at the default).
// Reset (synchronous, active low) sets south_count to 1024 and runs the same clearing pass,
// as does a configuration write. The receiver cannot stall the result.
`default_nettype none

module bilayer_crossing_counter
    import bcc_pkg::*;
#(
    parameter int MAX_SOUTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_in_item           i_item,
    output logic                    o_result_valid,
    output t_out_item               o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [SOUTH_W-1:0] i_cfg_data
);

    // South count never exceeds 2047, so the tree never needs more leaves than that covers.
    localparam int EFF_MAX  = (MAX_SOUTH < 2047) ? MAX_SOUTH : 2047;
    localparam int LEAF_MAX = 2 ** $clog2(EFF_MAX);
    localparam int NODES    = 2 * LEAF_MAX - 1;
    localparam int AW       = $clog2(NODES);
    localparam int QW       = $clog2(EFF_MAX + 1);
    localparam int LW       = $clog2(LEAF_MAX + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_RESULT = 4'b0100,
        ST_CLEAR  = 4'b1000
    } t_state;

    // Clamp a written south count to the supported maximum.
    function automatic logic [QW-1:0] f_eff_q(input logic [SOUTH_W-1:0] sc);
        logic [QW-1:0] q;
        q = (CALC_W'(sc) > CALC_W'(EFF_MAX)) ? QW'(EFF_MAX) : QW'(sc);
        return q;
    endfunction

    // Smallest power of two that is at least q (one leaf for q of zero or one).
    function automatic logic [LW-1:0] f_leaves(input logic [QW-1:0] q);
        logic [LW-1:0] lv;
        logic [QW-1:0] qm1;
        lv  = LW'(1);
        qm1 = q - QW'(1);
        if (q > QW'(1)) begin
            for (int i = 0; i < QW; i++) begin
                if ((qm1 >> i) != '0) begin
                    lv = LW'(1) << (i + 1);
                end
            end
        end
        return lv;
    endfunction

    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_last, n_last;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_err, n_err;
    logic               r_sat, n_sat;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic [QW-1:0]      r_q, n_q;
    logic [LW-1:0]      r_leaves, n_leaves;

    logic               accept;
    logic               in_range;
    logic [AW-1:0]      leaf_idx;
    logic [AW-1:0]      parent_idx;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      sib_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [NODE_W-1:0]  mem_wdata;
    logic [NODE_W-1:0]  node_q;
    logic [NODE_W-1:0]  sib_q;
    t_step_res          step;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = CALC_W'(i_item.south_position) < CALC_W'(r_q);
    assign leaf_idx = AW'(CALC_W'(i_item.south_position) + CALC_W'(r_leaves) - CALC_W'(1));
    assign parent_idx = (r_idx - AW'(1)) >> 1;

    // Odd nodes are left children; fetch their right sibling alongside.
    assign sib_addr = rd_addr[0] ? rd_addr + AW'(1) : rd_addr;

    bcc_tree_mem #(
        .DEPTH (NODES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (rd_addr),
        .i_raddr_b (sib_addr),
        .o_rdata_a (node_q),
        .o_rdata_b (sib_q)
    );

    bcc_step_unit u_step (
        .i_node     (node_q),
        .i_sib      (sib_q),
        .i_total    (r_total),
        .i_take_sib (r_idx[0]),
        .o_res      (step)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last      = r_last;
        n_total     = r_total;
        n_err       = r_err;
        n_sat       = r_sat;
        n_clr_addr  = r_clr_addr;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_q         = r_q;
        n_leaves    = r_leaves;
        rd_addr     = leaf_idx;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = step.node_next;

        unique case (r_state)
            ST_IDLE: begin
                // Launch the leaf read on accept; an out-of-range edge only flags, and ends the sequence if last.
                if (accept) begin
                    n_last = i_item.last_edge;
                    if (in_range) begin
                        n_idx   = leaf_idx;
                        n_state = ST_WALK;
                    end else begin
                        n_err   = 1'b1;
                        n_state = i_item.last_edge ? ST_RESULT : ST_IDLE;
                    end
                end
            end
            ST_WALK: begin
                // Write back this level, fold in the sibling, fetch the parent until the root is done.
                mem_we  = 1'b1;
                n_total = step.total_next;
                n_sat   = r_sat | step.sat;
                if (r_idx == '0) begin
                    n_state = r_last ? ST_RESULT : ST_IDLE;
                end else begin
                    n_idx   = parent_idx;
                    rd_addr = parent_idx;
                end
            end
            ST_RESULT: begin
                // Present the item for one cycle, drop the sequence state.
                n_out_valid           = 1'b1;
                n_out.crossing_total  = r_total;
                n_out.position_error  = r_err;
                n_out.total_saturated = r_sat;
                n_total               = '0;
                n_err                 = 1'b0;
                n_sat                 = 1'b0;
                n_clr_addr            = '0;
                n_state               = ST_CLEAR;
            end
            ST_CLEAR: begin
                // Zero one node per cycle.
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new south count starts a fresh sequence.
        if (i_cfg_we) begin
            n_q        = f_eff_q(i_cfg_data);
            n_leaves   = f_leaves(f_eff_q(i_cfg_data));
            n_total    = '0;
            n_err      = 1'b0;
            n_sat      = 1'b0;
            n_clr_addr = '0;
            n_state    = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_err       <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_q         <= f_eff_q(SOUTH_RESET);
            r_leaves    <= f_leaves(f_eff_q(SOUTH_RESET));
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_err       <= n_err;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            r_q         <= n_q;
            r_leaves    <= n_leaves;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

FILE: verif/bcc_checker.sv
// Checker for the bilayer crossing counter: predicts each sequence result and compares it.
module bcc_checker
    import bcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_in_item           i_item,
    input  logic               i_result_valid,
    input  t_out_item          i_result,
    input  logic               i_cfg_we,
    input  logic [SOUTH_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SOUTH_LIMIT = 1024;
    localparam int TREE_SLOTS  = 4 * SOUTH_LIMIT;

    logic [NODE_W-1:0]  node_count [TREE_SLOTS];
    logic [TOTAL_W-1:0] crossing_acc;
    logic               range_fault;
    logic               clamp_seen;
    logic [SOUTH_W-1:0] south_cfg;
    t_out_item          sequence_results [$];
    int                 fail_count;
    int                 results_seen;

    initial begin
        fail_count     = 0;
        results_seen   = 0;
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_tree();
        for (int k = 0; k < TREE_SLOTS; k++) begin
            node_count[k] = '0;
        end
        crossing_acc = '0;
        range_fault  = 1'b0;
        clamp_seen   = 1'b0;
    endtask

    task automatic bump_node(input int idx);
        if (idx < TREE_SLOTS && node_count[idx] != NODE_MAX) begin
            node_count[idx] = node_count[idx] + 1'b1;
        end
    endtask

    // Walk leaf to root; leaving a left child adds the right sibling's count.
    task automatic insert_edge(input int pos, input int q);
        int               leaves;
        int               idx;
        logic [TOTAL_W:0] sum;
        leaves = 1;
        while (leaves < q) leaves = leaves * 2;
        idx = pos + leaves - 1;
        bump_node(idx);
        while (idx > 0) begin
            if ((idx % 2) != 0 && idx + 1 < TREE_SLOTS) begin
                sum = {1'b0, crossing_acc};
                sum = sum + node_count[idx + 1];
                if (sum > {1'b0, TOTAL_MAX}) begin
                    crossing_acc = TOTAL_MAX;
                    clamp_seen   = 1'b1;
                end else begin
                    crossing_acc = sum[TOTAL_W-1:0];
                end
            end
            idx = (idx - 1) / 2;
            bump_node(idx);
        end
    endtask

    task automatic predict_edge(input t_in_item it);
        int        q;
        t_out_item res;
        q = (south_cfg > SOUTH_LIMIT) ? SOUTH_LIMIT : int'(south_cfg);
        if (int'(it.south_position) < q) begin
            insert_edge(int'(it.south_position), q);
        end else begin
            range_fault = 1'b1;
        end
        if (it.last_edge) begin
            res.crossing_total  = crossing_acc;
            res.position_error  = range_fault;
            res.total_saturated = clamp_seen;
            sequence_results.push_back(res);
            clear_tree();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            south_cfg = SOUTH_RESET;
            clear_tree();
            sequence_results.delete();
        end else begin
            if (i_cfg_we) begin
                south_cfg = i_cfg_data;
                clear_tree();
            end
            if (i_result_valid) begin
                results_seen++;
                if (sequence_results.size() == 0) begin
                    report_mismatch("result with no sequence pending",
                                    i_result.crossing_total, 0);
                end else begin
                    want = sequence_results.pop_front();
                    if (i_result.crossing_total !== want.crossing_total)
                        report_mismatch("crossing_total", i_result.crossing_total,
                                        want.crossing_total);
                    if (i_result.position_error !== want.position_error)
                        report_mismatch("position_error", i_result.position_error,
                                        want.position_error);
                    if (i_result.total_saturated !== want.total_saturated)
                        report_mismatch("total_saturated", i_result.total_saturated,
                                        want.total_saturated);
                end
            end
            if (i_start && !i_busy) predict_edge(i_item);
        end
        o_fail_count   <= fail_count;
        o_pending      <= sequence_results.size();
        o_results_seen <= results_seen;
    end

endmodule

FILE: verif/tb_bilayer_crossing_counter.sv
// Testbench top of the bilayer crossing counter: edge stimulus, watchdog and verdict.
module tb_bilayer_crossing_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int TARGET_EDGES   = 1050;
    // The limit allows the clearing pass after reset, a write or a last edge many times over.
    localparam int WATCHDOG_LIMIT = 20000;
    // Longest walk (11 levels) plus the result delay, with margin.
    localparam int SETTLE_CYCLES  = 20;
    localparam int END_CYCLES     = 64;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    t_in_item           i_item     = '0;
    logic               o_result_valid;
    t_out_item          o_result;
    logic               i_cfg_we   = 1'b0;
    logic [SOUTH_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int results_seen;

    int south_now      = 1024;
    int burst_left     = 0;
    int edges_sent     = 0;
    int sequences_done = 0;
    int cfg_writes     = 0;
    int abandoned      = 0;
    int idle_cycles    = 0;

    bilayer_crossing_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    bcc_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count cycles with no item, no result and no write; end the run if it stalls.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, idle_cycles);
            $display("** bilayer_crossing_counter: FAILED **");
            $finish;
        end
    end

    // Offer one edge and hold it until the block takes it. The sender works in bursts:
    // when a burst runs out, drop start for a random gap (sometimes none) and pick a new
    // burst length, now and then a long one so that back-to-back stretches occur too.
    task automatic send_edge(input int pos, input logic last);
        int       gap;
        t_in_item item;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        item.south_position = POS_W'(pos);
        item.last_edge      = last;
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        edges_sent++;
    endtask

    // Hold off until every expected result is in, let any walk still running finish,
    // and wait out the clearing pass. The first clock edge is skipped, since the pending
    // count is registered behind the accepted item.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Write south_count; only call this after settle(). The write also starts a new sequence.
    task automatic write_south(input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= SOUTH_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        south_now   = value;
        cfg_writes++;
    endtask

    // Send one sequence of random positions. Unless the south count is zero, most fall in
    // range; below 1024, fault_pct percent land at or above it. With closed low no edge is marked last.
    task automatic run_sequence(input int len, input int fault_pct, input logic closed);
        int q;
        int pos;
        q = (south_now > 1024) ? 1024 : south_now;
        for (int i = 0; i < len; i++) begin
            if (q == 0 || (q < 1024 && $urandom_range(0, 99) < fault_pct)) begin
                pos = $urandom_range(q, 1023);
            end else begin
                pos = $urandom_range(0, q - 1);
            end
            send_edge(pos, closed && (i == len - 1));
        end
        if (closed) sequences_done++;
    endtask

    initial begin : stimulus
        int south_picks [8];
        int kind;
        int len;
        int phase;
        int n_seq;
        south_picks = '{1, 2, 1024, 2047, 0, 1023, 3, 512};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Default south_count: extreme positions, one crossing, then none, then a lone edge.
        send_edge(1023, 1'b0);
        send_edge(0, 1'b1);
        send_edge(0, 1'b0);
        send_edge(1023, 1'b1);
        send_edge(512, 1'b1);

        // Out-of-range edges are flagged and skipped, the last edge among them.
        settle();
        write_south(5);
        send_edge(5, 1'b0);
        send_edge(4, 1'b0);
        send_edge(0, 1'b0);
        send_edge(1023, 1'b1);

        // Leaf count padded past a south count that is not a power of two.
        settle();
        write_south(3);
        send_edge(2, 1'b0);
        send_edge(1, 1'b0);
        send_edge(0, 1'b1);

        // Zero south count: nothing is in range and the tree has a single leaf.
        settle();
        write_south(0);
        send_edge(0, 1'b1);

        // All register bits set: the count clamps to the largest tree.
        settle();
        write_south(2047);
        send_edge(1023, 1'b0);
        send_edge(0, 1'b1);

        // A write in the middle of a sequence throws away what was counted so far.
        send_edge(700, 1'b0);
        send_edge(10, 1'b0);
        settle();
        write_south(1);
        abandoned++;
        send_edge(0, 1'b0);
        send_edge(0, 1'b0);
        send_edge(1, 1'b1);
        sequences_done += 8;

        // Random phases: each picks a south count, the fixed list first, then random ones.
        phase = 0;
        while (edges_sent < TARGET_EDGES) begin
            settle();
            if (phase < 8) begin
                write_south(south_picks[phase]);
            end else if ($urandom_range(0, 2) == 0) begin
                write_south($urandom_range(1, 40));
            end else begin
                write_south($urandom_range(1, 2047));
            end
            n_seq = $urandom_range(2, 6);
            for (int s = 0; s < n_seq; s++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0 && south_now >= 64) begin
                    len = $urandom_range(100, 250);
                end else begin
                    len = $urandom_range(1, 24);
                end
                if (kind == 1) begin
                    // Broken sequence: no last edge, then a rewrite starts over.
                    run_sequence(len, 10, 1'b0);
                    settle();
                    write_south(south_now);
                    abandoned++;
                end else begin
                    run_sequence(len, (kind == 3) ? 50 : 5, 1'b1);
                end
                // Now and then pause until every expected result has come back.
                if (kind == 2) settle();
            end
            phase++;
        end

        settle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Run covered %0d edges in %0d sequences over %0d south_count writes",
                 edges_sent, sequences_done, cfg_writes);
        $display("%0d abandoned sequences, %0d results checked", abandoned, results_seen);
        if (fail_count == 0) begin
            $display("** bilayer_crossing_counter: PASSED **");
        end else begin
            $display("** bilayer_crossing_counter: FAILED **");
        end
        $finish;
    end

endmodule
